[src/vcu_pkg.sv]
// ----------------------------------------------------------------------------
// vcu_pkg: shared definitions for the vector clock unit
// Operation, status and register codes, queue depths and the item structures
// that pass between the front end, the back end and the result queue.
// ----------------------------------------------------------------------------
package vcu_pkg;

    // Operation codes carried by an input item.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_MERGE   = 2'd1;
    localparam logic [1:0] OP_COMPARE = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_EQUAL         = 3'd1;
    localparam logic [2:0] ST_LOCAL_AFTER   = 3'd2;
    localparam logic [2:0] ST_LOCAL_BEFORE  = 3'd3;
    localparam logic [2:0] ST_CONCURRENT    = 3'd4;
    localparam logic [2:0] ST_SIZE_MISMATCH = 3'd5;
    localparam logic [2:0] ST_BAD_INDEX     = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_VECTOR_SIZE = 1'b0;
    localparam logic CFG_OWNER_INDEX = 1'b1;

    // Depth of the command queue and of the result queue.
    localparam int QUEUE_DEPTH  = 2;
    localparam int RESULT_DEPTH = 2;
    localparam int RCOUNT_W     = $clog2(RESULT_DEPTH + 1);

    // One decoded item waiting for the back end.
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] remote_value;
        logic        last;
        logic [3:0]  read_index;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
    } result_t;

endpackage

[src/vcu_fifo.sv]
// ----------------------------------------------------------------------------
// vcu_fifo: small first-in first-out queue
// Register-based queue with valid/ready on both sides and an occupancy count.
// ----------------------------------------------------------------------------
module vcu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [WIDTH-1:0]           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]   count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNW'(push) - CNW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[src/vcu_front.sv]
// ----------------------------------------------------------------------------
// vcu_front: input side of the vector clock unit
// Accepts items, clamps the remote element to the counter range and queues
// the decoded command for the back end.
// ----------------------------------------------------------------------------
module vcu_front #(
    parameter int COUNTER_BITS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_operation,
    input  logic [31:0]   s_remote_value,
    input  logic          s_last,
    input  logic [3:0]    s_read_index,
    input  logic          q_pop,
    output logic          q_valid,
    output vcu_pkg::cmd_t q_data
);
    import vcu_pkg::*;

    // Largest counter value, seen through the 32-bit element field.
    localparam logic [31:0] SAT_LIMIT = (COUNTER_BITS >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << COUNTER_BITS) - 64'd1);

    cmd_t cmd_in;

    always_comb begin
        cmd_in.operation    = s_operation;
        cmd_in.remote_value = (s_remote_value > SAT_LIMIT) ? SAT_LIMIT : s_remote_value;
        cmd_in.last         = s_last;
        cmd_in.read_index   = s_read_index;
    end

    vcu_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (cmd_in),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_data  (q_data),
        .count     ()
    );

endmodule

[src/vcu_back.sv]
// ----------------------------------------------------------------------------
// vcu_back: execution side of the vector clock unit
// Two-stage pipeline around the local clock memory: the issue stage tracks
// the open run and addresses the memories, the execute stage does the compare,
// maximum or increment and writes back. A committed merge sweeps the merge buffer
// into the local clock one entry per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module vcu_back #(
    parameter int MAX_PROCESSES = 16,
    parameter int COUNTER_BITS  = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [4:0]                   vector_size,
    input  logic [3:0]                   owner_index,
    input  logic                         q_valid,
    input  vcu_pkg::cmd_t                q_data,
    output logic                         q_pop,
    input  logic [vcu_pkg::RCOUNT_W-1:0] res_count,
    input  logic                         res_pop,
    output logic                         res_push,
    output vcu_pkg::result_t             res_data
);
    import vcu_pkg::*;

    localparam int AW   = $clog2(MAX_PROCESSES);
    localparam int CW   = $clog2(MAX_PROCESSES + 2);
    localparam int SW   = (CW > 5) ? CW : 5;
    localparam int CNTW = COUNTER_BITS;

    localparam logic [SW-1:0]   MAX_S   = SW'(MAX_PROCESSES);
    localparam logic [CW-1:0]   MAX_C   = CW'(MAX_PROCESSES);
    localparam logic [CNTW-1:0] CNT_MAX = '1;

    localparam logic [1:0] RUN_NONE    = 2'd0;
    localparam logic [1:0] RUN_MERGE   = 2'd1;
    localparam logic [1:0] RUN_COMPARE = 2'd2;

    // Run state, owned by the issue stage.
    logic [1:0]    run_kind_reg, run_kind_next;
    logic [CW-1:0] seen_reg, seen_next;
    logic          sweep_reg, sweep_next;
    logic [AW-1:0] sweep_idx_reg, sweep_idx_next;

    // Compare flags, owned by the execute stage.
    logic less_reg, less_next;
    logic greater_reg, greater_next;

    // Execute stage registers.
    logic            b_valid_reg, b_sweep_reg, b_err_reg, b_last_reg;
    logic            b_mismatch_reg, b_fresh_reg, b_cmp_reg;
    logic [1:0]      b_op_reg;
    logic [CNTW-1:0] b_value_reg;
    logic [AW-1:0]   b_addr_reg;

    // Memories.
    logic [CNTW-1:0]          clk_mem [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] clk_valid_reg;
    logic [CNTW-1:0]          clk_rd_reg;
    logic [CNTW-1:0]          buf_mem [MAX_PROCESSES];
    logic [CNTW-1:0]          buf_rd_reg;

    // Issue stage signals.
    logic [SW-1:0]       size_s;
    logic [RCOUNT_W:0]   fill_next;
    logic                room, issue_item, issue_sweep;
    logic [AW-1:0]       raddr;
    logic                a_err, a_fresh, a_cmp, a_mismatch;
    logic                buf_we;
    logic [1:0]          kind;
    logic                fresh;
    logic [CW-1:0]       seen_a, seen_inc;

    // Execute stage signals.
    logic            clk_we;
    logic [CNTW-1:0] clk_wdata, tick_val;
    logic            base_less, base_greater, new_less, new_greater;

    assign size_s = (SW'(vector_size) > MAX_S) ? MAX_S : SW'(vector_size);

    // Only issue when the result queue is sure to have a free slot for
    // whatever the execute stage produces next cycle.
    assign fill_next = {1'b0, res_count} + (RCOUNT_W + 1)'(b_valid_reg)
                     - (RCOUNT_W + 1)'(res_pop);
    assign room        = fill_next < (RCOUNT_W + 1)'(RESULT_DEPTH);
    assign issue_item  = !sweep_reg && q_valid && room;
    assign issue_sweep = sweep_reg && room;
    assign q_pop       = issue_item;

    assign kind     = (q_data.operation == OP_MERGE) ? RUN_MERGE : RUN_COMPARE;
    assign fresh    = (run_kind_reg != kind);
    assign seen_a   = fresh ? '0 : seen_reg;
    assign seen_inc = (seen_a <= MAX_C) ? seen_a + 1'b1 : seen_a;

    always_comb begin
        run_kind_next  = run_kind_reg;
        seen_next      = seen_reg;
        sweep_next     = sweep_reg;
        sweep_idx_next = sweep_idx_reg;
        raddr          = sweep_idx_reg;
        a_err          = 1'b0;
        a_fresh        = 1'b0;
        a_cmp          = 1'b0;
        a_mismatch     = 1'b0;
        buf_we         = 1'b0;
        if (issue_sweep) begin
            sweep_idx_next = sweep_idx_reg + 1'b1;
            if (SW'(sweep_idx_reg) + SW'(1) == size_s) begin
                sweep_next = 1'b0;
            end
        end else if (issue_item) begin
            unique case (q_data.operation)
                OP_TICK: begin
                    raddr = AW'(owner_index);
                    a_err = (SW'(owner_index) >= size_s);
                end
                OP_READ: begin
                    raddr = AW'(q_data.read_index);
                    a_err = (SW'(q_data.read_index) >= size_s);
                end
                OP_MERGE, OP_COMPARE: begin
                    raddr   = AW'(seen_a);
                    a_fresh = fresh;
                    a_cmp   = (kind == RUN_COMPARE) && (SW'(seen_a) < size_s);
                    buf_we  = (kind == RUN_MERGE) && (seen_a < MAX_C);
                    if (q_data.last) begin
                        run_kind_next = RUN_NONE;
                        seen_next     = '0;
                        a_mismatch    = (SW'(seen_inc) != size_s);
                        if ((kind == RUN_MERGE) && (SW'(seen_inc) == size_s)) begin
                            sweep_next     = 1'b1;
                            sweep_idx_next = '0;
                        end
                    end else begin
                        run_kind_next = kind;
                        seen_next     = seen_inc;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_kind_reg  <= RUN_NONE;
            seen_reg      <= '0;
            sweep_reg     <= 1'b0;
            sweep_idx_reg <= '0;
            less_reg      <= 1'b0;
            greater_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
        end else begin
            run_kind_reg  <= run_kind_next;
            seen_reg      <= seen_next;
            sweep_reg     <= sweep_next;
            sweep_idx_reg <= sweep_idx_next;
            less_reg      <= less_next;
            greater_reg   <= greater_next;
            b_valid_reg   <= issue_item || issue_sweep;
        end
    end

    always_ff @(posedge aclk) begin
        b_sweep_reg    <= issue_sweep;
        b_op_reg       <= q_data.operation;
        b_err_reg      <= a_err;
        b_last_reg     <= q_data.last;
        b_mismatch_reg <= a_mismatch;
        b_fresh_reg    <= a_fresh;
        b_cmp_reg      <= a_cmp;
        b_value_reg    <= CNTW'(q_data.remote_value);
        b_addr_reg     <= raddr;
    end

    // Local clock: one write and one registered read per cycle. A write to
    // the entry being read is passed straight to the read register, and an
    // entry not yet written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (clk_we) begin
            clk_mem[b_addr_reg] <= clk_wdata;
        end
        if (clk_we && (b_addr_reg == raddr)) begin
            clk_rd_reg <= clk_wdata;
        end else if (clk_valid_reg[raddr]) begin
            clk_rd_reg <= clk_mem[raddr];
        end else begin
            clk_rd_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_valid_reg <= '0;
        end else if (clk_we) begin
            clk_valid_reg[b_addr_reg] <= 1'b1;
        end
    end

    // Merge buffer: written by the issue stage, read by the sweep.
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[AW'(seen_a)] <= CNTW'(q_data.remote_value);
        end
        buf_rd_reg <= buf_mem[sweep_idx_reg];
    end

    assign base_less    = b_fresh_reg ? 1'b0 : less_reg;
    assign base_greater = b_fresh_reg ? 1'b0 : greater_reg;
    assign new_less     = base_less || (b_cmp_reg && (clk_rd_reg < b_value_reg));
    assign new_greater  = base_greater || (b_cmp_reg && (clk_rd_reg > b_value_reg));
    assign tick_val     = (clk_rd_reg == CNT_MAX) ? clk_rd_reg : clk_rd_reg + 1'b1;

    always_comb begin
        clk_we         = 1'b0;
        clk_wdata      = tick_val;
        res_push       = 1'b0;
        res_data       = '{status: ST_OK, value: 32'd0};
        less_next      = less_reg;
        greater_next   = greater_reg;
        if (b_valid_reg) begin
            if (b_sweep_reg) begin
                clk_we    = 1'b1;
                clk_wdata = (buf_rd_reg > clk_rd_reg) ? buf_rd_reg : clk_rd_reg;
            end else begin
                unique case (b_op_reg)
                    OP_TICK: begin
                        res_push = 1'b1;
                        if (b_err_reg) begin
                            res_data.status = ST_BAD_INDEX;
                        end else begin
                            clk_we         = 1'b1;
                            res_data.value = 32'(tick_val);
                        end
                    end
                    OP_READ: begin
                        res_push = 1'b1;
                        if (b_err_reg) begin
                            res_data.status = ST_BAD_INDEX;
                        end else begin
                            res_data.value = 32'(clk_rd_reg);
                        end
                    end
                    OP_MERGE, OP_COMPARE: begin
                        if (b_last_reg) begin
                            res_push     = 1'b1;
                            less_next    = 1'b0;
                            greater_next = 1'b0;
                            priority if (b_mismatch_reg) begin
                                res_data.status = ST_SIZE_MISMATCH;
                            end else if (b_op_reg == OP_MERGE) begin
                                res_data.status = ST_OK;
                            end else if (!new_less && !new_greater) begin
                                res_data.status = ST_EQUAL;
                            end else if (!new_less) begin
                                res_data.status = ST_LOCAL_AFTER;
                            end else if (!new_greater) begin
                                res_data.status = ST_LOCAL_BEFORE;
                            end else begin
                                res_data.status = ST_CONCURRENT;
                            end
                        end else begin
                            less_next    = new_less;
                            greater_next = new_greater;
                        end
                    end
                endcase
            end
        end
    end

endmodule

[src/vector_clock_unit_core.sv]
// ----------------------------------------------------------------------------
// vector_clock_unit_core: local vector clock of one process
// Tick, read, merge and compare of a vector clock, with the remote vector
// streamed in one element per item.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid / s_ready  s_operation, s_remote_value, s_last,
//                                          s_read_index
//  m_       out        m_valid / m_ready  m_status, m_value
//  cfg_     in         cfg_we             cfg_index, cfg_data
//
// One item is taken per cycle while no sweep runs and the result queue has
// room. A merge whose size matches adds a sweep of the first vector_size
// entries, one local clock entry per cycle while the result queue has room,
// through the single write port of the local clock memory; no item leaves the
// command queue during the sweep. Reset clears the local clock at once through
// per-entry valid bits, so no clearing pass follows reset. Input and output
// stall independently: a two-entry command queue and a two-entry result queue
// part them.
module vector_clock_unit_core #(
    parameter int MAX_PROCESSES = 16,
    parameter int COUNTER_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    // Input items.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_remote_value,
    input  logic        s_last,
    input  logic [3:0]  s_read_index,
    // Result items.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_value
);
    import vcu_pkg::*;

    // Configuration registers: vector_size resets to sixteen entries in use.
    logic [4:0] vector_size_reg;
    logic [3:0] owner_index_reg;

    cmd_t                q_data;
    logic                q_valid, q_pop;
    result_t             res_in, res_out;
    logic                res_push;
    logic [RCOUNT_W-1:0] res_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_size_reg <= 5'd16;
            owner_index_reg <= 4'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_VECTOR_SIZE: vector_size_reg <= cfg_data;
                CFG_OWNER_INDEX: owner_index_reg <= cfg_data[3:0];
            endcase
        end
    end

    // The front end accepts and clamps each item and queues it.
    vcu_front #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_remote_value (s_remote_value),
        .s_last         (s_last),
        .s_read_index   (s_read_index),
        .q_pop          (q_pop),
        .q_valid        (q_valid),
        .q_data         (q_data)
    );

    // The back end runs the clock operations. It only issues an item when
    // the result queue is certain to take its result, so it never stalls
    // mid-pipeline.
    vcu_back #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .vector_size (vector_size_reg),
        .owner_index (owner_index_reg),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .res_count   (res_count),
        .res_pop     (m_valid && m_ready),
        .res_push    (res_push),
        .res_data    (res_in)
    );

    // Result queue acting as the output register.
    vcu_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_result_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_push),
        .in_ready  (),
        .in_data   (res_in),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out),
        .count     (res_count)
    );

    assign m_status = res_out.status;
    assign m_value  = res_out.value;

endmodule

[src/vcu_checker.sv]
// ----------------------------------------------------------------------------
// vcu_checker: port-level checks for the vector clock unit
// Watches the result channel and the reset behaviour of the top level.
// ----------------------------------------------------------------------------
module vcu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [31:0] m_value
);
    import vcu_pkg::*;

    // A result that waits keeps its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_value))
        else $error("result item changed while stalled");

    // Only tick and read results carry a value; every other status has zero.
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_value == 32'd0))
        else $error("non-zero value on a result that carries none");

    // After a reset cycle the command queue accepts items and the result queue is empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("queues not empty after reset");

endmodule

bind vector_clock_unit_core vcu_checker u_vcu_checker (.*);
